/* rtl/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle circumcircle package
// Shared constants, status codes and result types for the circumcircle block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int unsigned DEF_COORD_WIDTH = 24;
    localparam int unsigned OUT_WIDTH       = 32;

    // The offset quotient is clamped to 2^40, so 41 quotient bits suffice.
    localparam int unsigned QUOT_BITS    = 41;
    localparam logic [QUOT_BITS-1:0] OFFSET_CLAMP = QUOT_BITS'(1) << (QUOT_BITS - 1);

    localparam int unsigned ROOT_BITS = 32;
    localparam int unsigned RAD_BITS  = 2 * ROOT_BITS;

    localparam logic [31:0]        LIMIT_RESET = 32'd1;
    localparam logic signed [31:0] OUT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] OUT_MIN     = -32'sh7FFF_FFFF - 32'sd1;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] cx;
        logic signed [OUT_WIDTH-1:0] cy;
        logic                        satc;
        logic                        rsat;
        logic                        degen;
    } t_post;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] center_x;
        logic signed [OUT_WIDTH-1:0] center_y;
        logic [OUT_WIDTH-1:0]        radius;
        t_status                     status;
    } t_res;

endpackage

`default_nettype wire

/* rtl/tcc_if.sv */
// ----------------------------------------------------------------------------
// Triangle circumcircle channels
// Valid/ready channels for the triangle corners and the circle result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if #(
    parameter int unsigned CW = tcc_pkg::DEF_COORD_WIDTH
) ();
    logic              valid;
    logic              ready;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;

    modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                    input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                    output ready);
endinterface

interface tcc_out_if ();
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   center_x;
    logic signed [31:0]   center_y;
    logic [31:0]          radius;
    tcc_pkg::t_status     status;

    modport source (output valid, center_x, center_y, radius, status, input ready);
    modport sink   (input valid, center_x, center_y, radius, status, output ready);
endinterface

`default_nettype wire

/* rtl/tcc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div #(
    parameter int unsigned N_W = 80,
    parameter int unsigned D_W = 51,
    parameter int unsigned Q_W = 41
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic [Q_W-1:0]      o_quot,
    output logic                o_ovf
);

    localparam int unsigned H_W = N_W - Q_W;
    localparam int unsigned C_W = (H_W > D_W) ? H_W : D_W;

    logic [D_W-1:0] r_rem [0:Q_W-1];
    logic [D_W-1:0] r_den [0:Q_W-1];
    logic [Q_W-1:0] r_lo  [0:Q_W-1];
    logic [Q_W-1:0] r_q   [0:Q_W];
    logic           r_ovf [0:Q_W];

    logic [C_W-1:0] w_hi;
    logic [C_W-1:0] w_den;

    assign w_hi  = C_W'(i_num[N_W-1:Q_W]);
    assign w_den = C_W'(i_den);

    // The quotient fits only if the upper numerator part is below the divisor,
    // which also keeps every partial remainder below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= (w_hi >= w_den);
            r_rem[0] <= w_hi[D_W-1:0];
            r_den[0] <= i_den;
            r_lo[0]  <= i_num[Q_W-1:0];
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [D_W:0] w_trial;
        logic [D_W:0] w_diff;
        logic         w_ge;

        assign w_trial = {r_rem[k-1], r_lo[k-1][Q_W-1]};
        assign w_ge    = (w_trial >= {1'b0, r_den[k-1]});
        assign w_diff  = w_trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {r_q[k-1][Q_W-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < Q_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
                    r_den[k] <= r_den[k-1];
                    r_lo[k]  <= r_lo[k-1] << 1;
                end
            end
        end
    end

    assign o_quot = r_q[Q_W];
    assign o_ovf  = r_ovf[Q_W];

endmodule

`default_nettype wire

/* rtl/tcc_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floored root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [tcc_pkg::RAD_BITS-1:0] i_rad,
    output logic [tcc_pkg::ROOT_BITS-1:0]     o_root
);

    localparam int unsigned RB = tcc_pkg::ROOT_BITS;
    localparam int unsigned NB = tcc_pkg::RAD_BITS;

    logic [RB+1:0] r_rem  [0:RB-2];
    logic [NB-1:0] r_rad  [0:RB-2];
    logic [RB-1:0] r_root [0:RB-1];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+1:0] w_rem_in;
        logic [NB-1:0] w_rad_in;
        logic [RB-1:0] w_root_in;
        logic [RB+1:0] w_cur;
        logic [RB+1:0] w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_rad_in  = i_rad;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_root_in = r_root[k-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign w_cur   = {w_rem_in[RB-1:0], w_rad_in[NB-1:NB-2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {w_root_in[RB-2:0], w_ge};
            end
        end

        if (k < RB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? (w_cur - w_trial) : w_cur;
                    r_rad[k] <= w_rad_in << 2;
                end
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule

`default_nettype wire

/* rtl/triangle_circumcircle.sv */
// ----------------------------------------------------------------------------
// Triangle circumcircle
// Circumcenter and floored circumradius of a 2D fixed-point triangle.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle while the output buffer is not full or the
// output is ready; the depth comes from the 41-stage offset dividers and the
// 32-stage radius square root, all fully pipelined.
// A two-entry output buffer lets input beats continue while one result waits.
// Reset (synchronous, active low) empties the pipeline and sets the limit to 1.
`default_nettype none

module triangle_circumcircle #(
    parameter int unsigned COORD_WIDTH = tcc_pkg::DEF_COORD_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tcc_in_if.sink           i_tri,
    tcc_out_if.source        o_circ,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam int unsigned CW   = COORD_WIDTH;
    localparam int unsigned W_DL = CW + 1;
    localparam int unsigned W_P  = 2 * W_DL;
    localparam int unsigned W_DM = W_P + 1;
    localparam int unsigned W_SQ = W_P;
    localparam int unsigned H    = W_SQ / 2;
    localparam int unsigned W_HI = W_SQ - H;
    localparam int unsigned W_PP = W_DL + W_HI + 1;
    localparam int unsigned W_N  = W_DL + W_SQ + 2;
    localparam int unsigned QW   = tcc_pkg::QUOT_BITS;
    localparam int unsigned RB   = tcc_pkg::ROOT_BITS;
    localparam int unsigned W_ND = (W_N > QW + 1) ? W_N : QW + 1;
    localparam int unsigned W_CL = (W_DM > 32) ? W_DM : 32;
    localparam int unsigned W_S  = ((CW > QW + 1) ? CW : QW + 1) + 1;
    localparam int unsigned LAT  = 11 + QW + RB;

    localparam logic signed [W_S-1:0] SAT_HI = W_S'(tcc_pkg::OUT_MAX);
    localparam logic signed [W_S-1:0] SAT_LO = W_S'(tcc_pkg::OUT_MIN);

    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic                 degen;
        logic                 sx;
        logic                 sy;
    } t_side;

    logic        w_en;
    logic        w_push;
    logic        w_pop;
    logic [31:0] r_limit;
    logic [1:0]  r_cnt;
    logic        r_vld [0:LAT-1];

    tcc_pkg::t_res r_head;
    tcc_pkg::t_res r_skid;
    tcc_pkg::t_res n_res;

    // Stage 1: edge vectors.
    t_side                   r1_sb;
    logic signed [W_DL-1:0]  r1_ax, r1_ay, r1_bx, r1_by;
    // Stage 2: products.
    t_side                   r2_sb;
    logic signed [W_DL-1:0]  r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [W_P-1:0]   r2_axby, r2_aybx, r2_axax, r2_ayay, r2_bxbx, r2_byby;
    // Stage 3: denominator and squared lengths.
    t_side                   r3_sb;
    logic signed [W_DL-1:0]  r3_ax, r3_ay, r3_bx, r3_by;
    logic signed [W_P+1:0]   r3_d;
    logic [W_SQ-1:0]         r3_asq, r3_bsq;
    logic signed [W_P:0]     n3_cross;
    logic signed [W_P:0]     n3_asq, n3_bsq;
    // Stage 4: magnitude test and partial products.
    t_side                   r4_sb;
    logic [W_DM-1:0]         r4_dm, n4_dm;
    logic                    r4_dneg;
    logic signed [W_PP-1:0]  r4_byasq_l, r4_byasq_h, r4_aybsq_l, r4_aybsq_h;
    logic signed [W_PP-1:0]  r4_axbsq_l, r4_axbsq_h, r4_bxasq_l, r4_bxasq_h;
    // Stage 5: full products.
    t_side                   r5_sb;
    logic [W_DM-1:0]         r5_dm;
    logic                    r5_dneg;
    logic signed [W_N-1:0]   r5_byasq, r5_aybsq, r5_axbsq, r5_bxasq;
    // Stage 6: numerators.
    t_side                   r6_sb;
    logic [W_DM-1:0]         r6_dm;
    logic                    r6_dneg;
    logic signed [W_N-1:0]   r6_nx, r6_ny;
    // Stage 7: magnitudes and quotient signs.
    t_side                   r7_sb;
    logic [W_DM-1:0]         r7_dm;
    logic [W_N-1:0]          r7_nxm, r7_nym;
    // Divider side band and outputs.
    t_side                   r_sbd [0:QW];
    logic [QW-1:0]           w_qx, w_qy;
    logic                    w_ovx, w_ovy;
    // Stage 8: clamped offsets.
    t_side                   r8_sb;
    logic [QW-1:0]           r8_qmx, r8_qmy, n8_qmx, n8_qmy;
    logic signed [QW:0]      r8_cx, r8_cy;
    // Stage 9: center and offset squares.
    tcc_pkg::t_post          r9_post;
    logic                    r9_big;
    logic [63:0]             r9_sqx, r9_sqy;
    logic signed [W_S-1:0]   n9_sx, n9_sy;
    logic                    n9_hx, n9_lx, n9_hy, n9_ly;
    // Stage 10 onward: radius squared and the root pipeline.
    logic [64:0]             n10_r2;
    logic [63:0]             r10_rad;
    tcc_pkg::t_post          r_post [0:RB];
    logic [RB-1:0]           w_root;

    assign w_en        = (r_cnt != 2'd2) || o_circ.ready;
    assign i_tri.ready = w_en;
    assign w_push      = w_en && r_vld[LAT-1];
    assign w_pop       = o_circ.valid && o_circ.ready;

    always_comb begin
        n3_cross = (W_P+1)'(r2_axby) - (W_P+1)'(r2_aybx);
        n3_asq   = (W_P+1)'(r2_axax) + (W_P+1)'(r2_ayay);
        n3_bsq   = (W_P+1)'(r2_bxbx) + (W_P+1)'(r2_byby);
        n4_dm    = W_DM'(r3_d[W_P+1] ? -r3_d : r3_d);

        // Quotients above 2^40 or flagged as divider overflow are pinned to 2^40; those always saturate later.
        n8_qmx = (w_ovx || (w_qx > tcc_pkg::OFFSET_CLAMP)) ? tcc_pkg::OFFSET_CLAMP : w_qx;
        n8_qmy = (w_ovy || (w_qy > tcc_pkg::OFFSET_CLAMP)) ? tcc_pkg::OFFSET_CLAMP : w_qy;

        n9_sx = W_S'(r8_sb.x0) + W_S'(r8_cx);
        n9_sy = W_S'(r8_sb.y0) + W_S'(r8_cy);
        n9_hx = (n9_sx > SAT_HI);
        n9_lx = (n9_sx < SAT_LO);
        n9_hy = (n9_sy > SAT_HI);
        n9_ly = (n9_sy < SAT_LO);

        n10_r2 = {1'b0, r9_sqx} + {1'b0, r9_sqy};

        n_res.center_x = '0;
        n_res.center_y = '0;
        n_res.radius   = '0;
        n_res.status   = tcc_pkg::ST_DEGEN;
        if (!r_post[RB].degen) begin
            n_res.center_x = r_post[RB].cx;
            n_res.center_y = r_post[RB].cy;
            n_res.radius   = r_post[RB].rsat ? '1 : w_root;
            n_res.status   = (r_post[RB].satc || r_post[RB].rsat) ? tcc_pkg::ST_SAT
                                                                  : tcc_pkg::ST_VALID;
        end
    end

    // Control state: limit register, valid bits and output buffer fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tcc_pkg::LIMIT_RESET;
            r_cnt   <= '0;
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
            if (w_en) begin
                r_vld[0] <= i_tri.valid;
                for (int i = 1; i < LAT; i++) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_head <= r_skid;
                if (w_push) begin
                    r_skid <= n_res;
                end
            end else if (w_push) begin
                r_head <= n_res;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sb.x0    <= i_tri.first_x;
            r1_sb.y0    <= i_tri.first_y;
            r1_sb.degen <= 1'b0;
            r1_sb.sx    <= 1'b0;
            r1_sb.sy    <= 1'b0;
            r1_ax <= W_DL'(i_tri.second_x) - W_DL'(i_tri.first_x);
            r1_ay <= W_DL'(i_tri.second_y) - W_DL'(i_tri.first_y);
            r1_bx <= W_DL'(i_tri.third_x) - W_DL'(i_tri.first_x);
            r1_by <= W_DL'(i_tri.third_y) - W_DL'(i_tri.first_y);

            r2_sb   <= r1_sb;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_axby <= r1_ax * r1_by;
            r2_aybx <= r1_ay * r1_bx;
            r2_axax <= r1_ax * r1_ax;
            r2_ayay <= r1_ay * r1_ay;
            r2_bxbx <= r1_bx * r1_bx;
            r2_byby <= r1_by * r1_by;

            r3_sb  <= r2_sb;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
            r3_d   <= {n3_cross, 1'b0};
            r3_asq <= n3_asq[W_SQ-1:0];
            r3_bsq <= n3_bsq[W_SQ-1:0];

            // A zero denominator is degenerate even with a zero limit.
            r4_sb.x0    <= r3_sb.x0;
            r4_sb.y0    <= r3_sb.y0;
            r4_sb.degen <= (n4_dm == '0) || (W_CL'(n4_dm) < W_CL'(r_limit));
            r4_sb.sx    <= r3_sb.sx;
            r4_sb.sy    <= r3_sb.sy;
            r4_dm       <= n4_dm;
            r4_dneg     <= r3_d[W_P+1];
            r4_byasq_l  <= r3_by * $signed({1'b0, r3_asq[H-1:0]});
            r4_byasq_h  <= r3_by * $signed({1'b0, r3_asq[W_SQ-1:H]});
            r4_aybsq_l  <= r3_ay * $signed({1'b0, r3_bsq[H-1:0]});
            r4_aybsq_h  <= r3_ay * $signed({1'b0, r3_bsq[W_SQ-1:H]});
            r4_axbsq_l  <= r3_ax * $signed({1'b0, r3_bsq[H-1:0]});
            r4_axbsq_h  <= r3_ax * $signed({1'b0, r3_bsq[W_SQ-1:H]});
            r4_bxasq_l  <= r3_bx * $signed({1'b0, r3_asq[H-1:0]});
            r4_bxasq_h  <= r3_bx * $signed({1'b0, r3_asq[W_SQ-1:H]});

            r5_sb    <= r4_sb;
            r5_dm    <= r4_dm;
            r5_dneg  <= r4_dneg;
            r5_byasq <= (W_N'(r4_byasq_h) <<< H) + W_N'(r4_byasq_l);
            r5_aybsq <= (W_N'(r4_aybsq_h) <<< H) + W_N'(r4_aybsq_l);
            r5_axbsq <= (W_N'(r4_axbsq_h) <<< H) + W_N'(r4_axbsq_l);
            r5_bxasq <= (W_N'(r4_bxasq_h) <<< H) + W_N'(r4_bxasq_l);

            r6_sb   <= r5_sb;
            r6_dm   <= r5_dm;
            r6_dneg <= r5_dneg;
            r6_nx   <= r5_byasq - r5_aybsq;
            r6_ny   <= r5_axbsq - r5_bxasq;

            r7_sb.x0    <= r6_sb.x0;
            r7_sb.y0    <= r6_sb.y0;
            r7_sb.degen <= r6_sb.degen;
            r7_sb.sx    <= r6_nx[W_N-1] ^ r6_dneg;
            r7_sb.sy    <= r6_ny[W_N-1] ^ r6_dneg;
            r7_dm       <= r6_dm;
            r7_nxm      <= W_N'(r6_nx[W_N-1] ? -r6_nx : r6_nx);
            r7_nym      <= W_N'(r6_ny[W_N-1] ? -r6_ny : r6_ny);

            r_sbd[0] <= r7_sb;
            for (int i = 1; i <= QW; i++) begin
                r_sbd[i] <= r_sbd[i-1];
            end

            r8_sb  <= r_sbd[QW];
            r8_qmx <= n8_qmx;
            r8_qmy <= n8_qmy;
            r8_cx  <= r_sbd[QW].sx ? -$signed({1'b0, n8_qmx}) : $signed({1'b0, n8_qmx});
            r8_cy  <= r_sbd[QW].sy ? -$signed({1'b0, n8_qmy}) : $signed({1'b0, n8_qmy});

            r9_post.cx    <= n9_hx ? tcc_pkg::OUT_MAX : n9_lx ? tcc_pkg::OUT_MIN
                                                              : n9_sx[31:0];
            r9_post.cy    <= n9_hy ? tcc_pkg::OUT_MAX : n9_ly ? tcc_pkg::OUT_MIN
                                                              : n9_sy[31:0];
            r9_post.satc  <= n9_hx || n9_lx || n9_hy || n9_ly;
            r9_post.rsat  <= 1'b0;
            r9_post.degen <= r8_sb.degen;
            // An offset of 2^32 or more squares past 64 bits on its own.
            r9_big <= (r8_qmx[QW-1:32] != '0) || (r8_qmy[QW-1:32] != '0);
            r9_sqx <= r8_qmx[31:0] * r8_qmx[31:0];
            r9_sqy <= r8_qmy[31:0] * r8_qmy[31:0];

            r10_rad         <= n10_r2[63:0];
            r_post[0].cx    <= r9_post.cx;
            r_post[0].cy    <= r9_post.cy;
            r_post[0].satc  <= r9_post.satc;
            r_post[0].rsat  <= r9_big || n10_r2[64];
            r_post[0].degen <= r9_post.degen;
            for (int i = 1; i <= RB; i++) begin
                r_post[i] <= r_post[i-1];
            end
        end
    end

    tcc_div #(
        .N_W (W_ND),
        .D_W (W_DM),
        .Q_W (QW)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (W_ND'(r7_nxm)),
        .i_den  (r7_dm),
        .o_quot (w_qx),
        .o_ovf  (w_ovx)
    );

    tcc_div #(
        .N_W (W_ND),
        .D_W (W_DM),
        .Q_W (QW)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (W_ND'(r7_nym)),
        .i_den  (r7_dm),
        .o_quot (w_qy),
        .o_ovf  (w_ovy)
    );

    tcc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r10_rad),
        .o_root (w_root)
    );

    assign o_circ.valid    = (r_cnt != 2'd0);
    assign o_circ.center_x = r_head.center_x;
    assign o_circ.center_y = r_head.center_y;
    assign o_circ.radius   = r_head.radius;
    assign o_circ.status   = r_head.status;

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_circ.valid && o_circ.status == tcc_pkg::ST_DEGEN) |->
        (o_circ.center_x == '0 && o_circ.center_y == '0 && o_circ.radius == '0))
        else $error("degenerate result carries nonzero fields");

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && !w_pop && r_cnt == 2'd2))
        else $error("result pushed into a full output buffer");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !o_circ.ready) |=> ($stable(r_vld[LAT-1]) && $stable(r_vld[0])))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
